FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed: next-cycle implication");

`endif

FILE: src/tcon_pkg.sv
`default_nettype none

package tcon_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	localparam logic [7:0] CH_RETURN   = 8'h0D;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] COLOR_RESET = 8'd23;

	localparam logic [15:0] BLANK_ENTRY = {COLOR_RESET, CH_SPACE};

	typedef enum logic [1:0] {
		MODE_PUT   = 2'd0,
		MODE_READ  = 2'd1,
		MODE_WRITE = 2'd2
	} tcon_mode_t;

	typedef struct packed {
		tcon_mode_t  mode;
		logic [7:0]  char_code;
		logic [7:0]  entry_color;
		logic [6:0]  cell_column;
		logic [4:0]  cell_row;
	} tcon_in_t;

	typedef struct packed {
		logic [15:0] read_entry;
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_column;
	} tcon_out_t;

endpackage

`default_nettype wire

FILE: src/tcon_store.sv
`default_nettype none

module tcon_store #(
	parameter int DEPTH = tcon_pkg::COLUMNS_DEF * tcon_pkg::ROWS_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem_q [DEPTH];
	logic [15:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: src/text_console_cursor_scroll.sv
// Text console: a ROWS x COLUMNS store of 16-bit cells (character low byte, attribute high
// byte) in one single-port-write, single-port-read memory, plus a cursor. The accept cycle
// reads the store, and the next cycle executes and writes back. A line advance past the
// bottom row adds a scroll pass (one cell copied or zeroed per cycle through the memory's
// read and write ports). After reset the store is cleared to spaces in the reset color
// in a pass before the first word is taken; configuration writes are taken at any time.
// Results wait in an output register, so the next word is accepted while a result is
// still held.
`default_nettype none

module text_console_cursor_scroll #(
	parameter int COLUMNS = tcon_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcon_pkg::ROWS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tcon_pkg::tcon_in_t  in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output tcon_pkg::tcon_out_t out_word,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);

	import tcon_pkg::*;

	localparam int CELLS     = COLUMNS * ROWS;
	localparam int SHIFT_CNT = COLUMNS * (ROWS - 1);
	localparam int AW        = $clog2(CELLS);
	localparam int RW        = $clog2(ROWS);
	localparam int CW        = $clog2(COLUMNS);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_SCROLL
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   sweep_q;
	logic [RW-1:0]   row_q;
	logic [CW-1:0]   col_q;
	logic [7:0]      text_color_q;

	tcon_in_t        item_s1;
	logic            inside_s1;
	logic [AW-1:0]   iaddr_s1;

	logic            swp_v_s1;
	logic            swp_copy_s1;
	logic [AW-1:0]   swp_addr_s1;
	logic [15:0]     swp_data_s1;

	tcon_out_t       out_q;
	logic            out_valid_q;
	tcon_out_t       res_q;
	logic            res_pend_q;

	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [15:0]     mem_wdata;
	logic [AW-1:0]   mem_raddr;
	logic [15:0]     mem_rdata;

	logic            in_inside;
	logic [AW-1:0]   in_addr;
	logic [AW-1:0]   cur_addr;
	logic [AW-1:0]   scroll_raddr;
	logic            scroll_copy;
	logic            sweep_last;
	logic            out_free;

	logic [RW-1:0]   nxt_row;
	logic [CW-1:0]   nxt_col;
	logic            adv;
	logic            do_scroll;
	logic            ex_we;
	logic [AW-1:0]   ex_addr;
	logic [15:0]     ex_data;
	logic [15:0]     rd;
	tcon_out_t       res_new;

	assign in_inside = (32'(in_word.cell_row) < ROWS) && (32'(in_word.cell_column) < COLUMNS);
	assign in_addr   = in_inside ?
		AW'(32'(in_word.cell_row) * COLUMNS + 32'(in_word.cell_column)) : '0;
	assign cur_addr     = AW'(32'(row_q) * COLUMNS + 32'(col_q));
	assign scroll_copy  = 32'(sweep_q) < SHIFT_CNT;
	assign scroll_raddr = scroll_copy ? AW'(32'(sweep_q) + COLUMNS) : '0;
	assign sweep_last   = 32'(sweep_q) == CELLS - 1;
	assign out_free     = !out_valid_q || out_ready;

	assign in_ready  = (state_q == S_IDLE) && !res_pend_q && !swp_v_s1;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;
	assign cfg_ready = 1'b1;

	// execute stage: cursor update, read result and write-back for the held item
	always_comb begin
		nxt_row   = row_q;
		nxt_col   = col_q;
		adv       = 1'b0;
		do_scroll = 1'b0;
		ex_we     = 1'b0;
		ex_addr   = cur_addr;
		ex_data   = {text_color_q, item_s1.char_code};
		rd        = '0;
		case (item_s1.mode)
			MODE_PUT: begin
				if (item_s1.char_code == CH_NEWLINE) begin
					nxt_col = '0;
					adv     = 1'b1;
				end else if (item_s1.char_code == CH_RETURN) begin
					nxt_col = '0;
				end else begin
					ex_we = 1'b1;
					if (32'(col_q) == COLUMNS - 1) begin
						nxt_col = '0;
						adv     = 1'b1;
					end else begin
						nxt_col = col_q + 1'b1;
					end
				end
			end
			MODE_READ: begin
				if (inside_s1) begin
					rd = mem_rdata;
				end
			end
			MODE_WRITE: begin
				if (inside_s1) begin
					ex_we   = 1'b1;
					ex_addr = iaddr_s1;
					ex_data = {item_s1.entry_color, item_s1.char_code};
				end
			end
			default: ;
		endcase
		// past the bottom row: hold the row and scroll instead
		if (adv) begin
			if (32'(row_q) == ROWS - 1) begin
				do_scroll = 1'b1;
			end else begin
				nxt_row = row_q + 1'b1;
			end
		end
		res_new.read_entry    = rd;
		res_new.cursor_row    = 5'(nxt_row);
		res_new.cursor_column = 7'(nxt_col);
	end

	assign mem_raddr = (state_q == S_SCROLL) ? scroll_raddr : in_addr;
	assign mem_we    = swp_v_s1 || ((state_q == S_EXEC) && ex_we);
	assign mem_waddr = swp_v_s1 ? swp_addr_s1 : ex_addr;
	assign mem_wdata = swp_v_s1 ? (swp_copy_s1 ? mem_rdata : swp_data_s1) : ex_data;

	tcon_store #(
		.DEPTH (CELLS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			sweep_q      <= '0;
			row_q        <= '0;
			col_q        <= '0;
			text_color_q <= COLOR_RESET;
			item_s1      <= '0;
			inside_s1    <= 1'b0;
			iaddr_s1     <= '0;
			swp_v_s1     <= 1'b0;
			swp_copy_s1  <= 1'b0;
			swp_addr_s1  <= '0;
			swp_data_s1  <= '0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
			res_q        <= '0;
			res_pend_q   <= 1'b0;
		end else begin
			swp_v_s1 <= 1'b0;
			if (cfg_valid) begin
				text_color_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (res_pend_q && out_free) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
				res_pend_q  <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					swp_v_s1    <= 1'b1;
					swp_copy_s1 <= 1'b0;
					swp_addr_s1 <= sweep_q;
					swp_data_s1 <= BLANK_ENTRY;
					if (sweep_last) begin
						sweep_q <= '0;
						state_q <= S_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_valid && in_ready) begin
						item_s1   <= in_word;
						inside_s1 <= in_inside;
						iaddr_s1  <= in_addr;
						state_q   <= S_EXEC;
					end
				end
				S_EXEC: begin
					row_q <= nxt_row;
					col_q <= nxt_col;
					if (out_free) begin
						out_q       <= res_new;
						out_valid_q <= 1'b1;
					end else begin
						res_q      <= res_new;
						res_pend_q <= 1'b1;
					end
					state_q <= do_scroll ? S_SCROLL : S_IDLE;
				end
				S_SCROLL: begin
					// copy the row below for all but the last row, then zero the last row
					swp_v_s1    <= 1'b1;
					swp_copy_s1 <= scroll_copy;
					swp_addr_s1 <= sweep_q;
					swp_data_s1 <= '0;
					if (sweep_last) begin
						sweep_q <= '0;
						state_q <= S_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/tcon_chk.sv
`include "assert_macros.svh"
`default_nettype none

module tcon_chk #(
	parameter int COLUMNS = tcon_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcon_pkg::ROWS_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input tcon_pkg::tcon_out_t out_word
);

	import tcon_pkg::*;

	// a stalled result stays up and unchanged
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_word))

	// an accepted word occupies the execute cycle
	`ASSERT_NEXT(a_in_gap, clk, arst_n, in_valid && in_ready, !in_ready)

	`ASSERT_IMPLIES(a_cursor_range, clk, arst_n, out_valid,
		(32'(out_word.cursor_row) < ROWS) && (32'(out_word.cursor_column) < COLUMNS))

endmodule

bind text_console_cursor_scroll tcon_chk #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcon_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);

`default_nettype wire

FILE: verif/tb_text_console_cursor_scroll.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_text_console_cursor_scroll;
	import tcon_pkg::*;

	localparam int COLS = COLUMNS_DEF;
	localparam int ROWS = ROWS_DEF;
	localparam tcon_mode_t MODE_UNUSED = tcon_mode_t'(2'd3);

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	tcon_in_t   in_word;
	logic       out_valid;
	logic       out_ready;
	tcon_out_t  out_word;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;

	text_console_cursor_scroll #(
		.COLUMNS(COLS),
		.ROWS(ROWS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Shadow of the console: cell store, cursor and print color.
	logic [15:0] screen_copy [ROWS*COLS];
	int          cur_row;
	int          cur_col;
	logic [7:0]  print_color;

	tcon_out_t   pending_results[$];
	int          errors;
	bit          idle_on;
	int          out_hold;

	always #5 clk = ~clk;

	task automatic advance_row();
		cur_row++;
		if (cur_row >= ROWS) begin
			// shift every row up, zero the bottom one
			for (int i = 0; i < (ROWS - 1) * COLS; i++)
				screen_copy[i] = screen_copy[i + COLS];
			for (int i = (ROWS - 1) * COLS; i < ROWS * COLS; i++)
				screen_copy[i] = 16'h0000;
			cur_row = ROWS - 1;
		end
	endtask

	task automatic console_step(input tcon_in_t w, output tcon_out_t r);
		int  row;
		int  col;
		bit  on_screen;
		row = w.cell_row;
		col = w.cell_column;
		on_screen = (row < ROWS) && (col < COLS);
		r = '0;
		case (w.mode)
			MODE_PUT: begin
				if (w.char_code == CH_NEWLINE) begin
					cur_col = 0;
					advance_row();
				end else if (w.char_code == CH_RETURN) begin
					cur_col = 0;
				end else begin
					screen_copy[cur_row * COLS + cur_col] = {print_color, w.char_code};
					cur_col++;
					if (cur_col >= COLS) begin
						cur_col = 0;
						advance_row();
					end
				end
			end
			MODE_READ: begin
				if (on_screen)
					r.read_entry = screen_copy[row * COLS + col];
			end
			MODE_WRITE: begin
				if (on_screen)
					screen_copy[row * COLS + col] = {w.entry_color, w.char_code};
			end
			default: ;
		endcase
		r.cursor_row = 5'(cur_row);
		r.cursor_column = 7'(cur_col);
	endtask

	function automatic tcon_in_t word_of(tcon_mode_t m, logic [7:0] ch, logic [7:0] color,
			logic [6:0] col, logic [4:0] row);
		tcon_in_t w;
		w.mode = m;
		w.char_code = ch;
		w.entry_color = color;
		w.cell_column = col;
		w.cell_row = row;
		return w;
	endfunction

	function automatic tcon_in_t random_word();
		tcon_in_t    w;
		logic [31:0] raw;
		int          pick;
		int          sel;
		raw = $urandom;
		w = raw[$bits(tcon_in_t)-1:0];
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			w.mode = MODE_PUT;
			sel = $urandom_range(0, 99);
			if (sel < 8)
				w.char_code = CH_NEWLINE;
			else if (sel < 12)
				w.char_code = CH_RETURN;
		end else if (pick < 95) begin
			if (pick < 75)
				w.mode = MODE_READ;
			else
				w.mode = MODE_WRITE;
			// mostly on-screen cells; raw bits otherwise
			if ($urandom_range(0, 9) != 0) begin
				w.cell_row = 5'($urandom_range(0, ROWS - 1));
				w.cell_column = 7'($urandom_range(0, COLS - 1));
				if (w.mode == MODE_READ && $urandom_range(0, 1) == 1)
					w.cell_row = 5'(cur_row);
			end
		end else begin
			w.mode = MODE_UNUSED;
		end
		return w;
	endfunction

	task automatic send_word(input tcon_in_t w);
		tcon_out_t r;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		console_step(w, r);
		pending_results.push_back(r);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_text_color(input logic [7:0] color);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= color;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		print_color = color;
	endtask

	task automatic check_cleared_screen();
		send_word(word_of(MODE_READ, 8'h00, 8'h00, 7'd0, 5'd0));
		send_word(word_of(MODE_READ, 8'h00, 8'h00, 7'(COLS - 1), 5'(ROWS - 1)));
		send_word(word_of(MODE_READ, 8'h00, 8'h00, 7'd42, 5'd13));
		send_word(word_of(MODE_READ, 8'h00, 8'h00, 7'd0, 5'(ROWS)));
		send_word(word_of(MODE_READ, 8'hFF, 8'hFF, 7'h7F, 5'h1F));
		send_word(word_of(MODE_READ, 8'h00, 8'h00, 7'(COLS), 5'd0));
		send_word(word_of(MODE_UNUSED, 8'hFF, 8'hFF, 7'h7F, 5'h1F));
	endtask

	task automatic check_cell_access();
		send_word(word_of(MODE_WRITE, 8'h00, 8'h00, 7'd0, 5'd0));
		send_word(word_of(MODE_READ, 8'hFF, 8'hFF, 7'd0, 5'd0));
		send_word(word_of(MODE_WRITE, 8'hFF, 8'hFF, 7'(COLS - 1), 5'(ROWS - 1)));
		send_word(word_of(MODE_READ, 8'h00, 8'h00, 7'(COLS - 1), 5'(ROWS - 1)));
		// off-screen writes must not land on a neighboring cell
		send_word(word_of(MODE_WRITE, 8'h55, 8'hAA, 7'(COLS), 5'd0));
		send_word(word_of(MODE_READ, 8'h00, 8'h00, 7'd0, 5'd1));
		send_word(word_of(MODE_WRITE, 8'h55, 8'hAA, 7'd0, 5'(ROWS)));
		send_word(word_of(MODE_READ, 8'h00, 8'h00, 7'd0, 5'(ROWS - 1)));
	endtask

	task automatic check_printing();
		send_word(word_of(MODE_PUT, 8'h00, 8'hFF, 7'h7F, 5'h1F));
		send_word(word_of(MODE_PUT, 8'hFF, 8'h00, 7'd0, 5'd0));
		send_word(word_of(MODE_PUT, 8'h41, 8'h00, 7'd0, 5'd0));
		send_word(word_of(MODE_PUT, CH_RETURN, 8'h00, 7'd0, 5'd0));
		send_word(word_of(MODE_PUT, 8'h42, 8'h00, 7'd0, 5'd0));
		send_word(word_of(MODE_PUT, CH_NEWLINE, 8'h00, 7'd0, 5'd0));
		send_word(word_of(MODE_READ, 8'h00, 8'h00, 7'd0, 5'd0));
		send_word(word_of(MODE_READ, 8'h00, 8'h00, 7'd1, 5'd0));
		send_word(word_of(MODE_READ, 8'h00, 8'h00, 7'd2, 5'd0));
	endtask

	task automatic check_random_traffic();
		logic [7:0] colors [6];
		colors[0] = 8'h00;
		colors[1] = 8'hFF;
		colors[2] = 8'($urandom);
		colors[3] = 8'h5A;
		colors[4] = 8'($urandom);
		colors[5] = COLOR_RESET;
		for (int p = 0; p < 6; p++) begin
			set_text_color(colors[p]);
			// last phase runs at full rate on both sides
			if (p == 5)
				idle_on = 1'b0;
			repeat (271) send_word(random_word());
		end
	endtask

	always @(posedge clk) begin
		if (out_hold > 0) begin
			out_hold <= out_hold - 1;
			out_ready <= (out_hold == 1);
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			out_hold <= $urandom_range(1, 10);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		tcon_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word %h", $time, out_word);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (out_word.read_entry !== want.read_entry) begin
					$display("%0t: read_entry expected %h actual %h", $time,
						want.read_entry, out_word.read_entry);
					errors++;
				end
				if (out_word.cursor_row !== want.cursor_row) begin
					$display("%0t: cursor_row expected %0d actual %0d", $time,
						want.cursor_row, out_word.cursor_row);
					errors++;
				end
				if (out_word.cursor_column !== want.cursor_column) begin
					$display("%0t: cursor_column expected %0d actual %0d", $time,
						want.cursor_column, out_word.cursor_column);
					errors++;
				end
			end
		end
	end

	initial begin
		#(200_000_000);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 8'h00;
		errors = 0;
		idle_on = 1'b1;
		out_hold = 0;
		cur_row = 0;
		cur_col = 0;
		print_color = COLOR_RESET;
		for (int i = 0; i < ROWS * COLS; i++)
			screen_copy[i] = BLANK_ENTRY;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_cleared_screen();
		check_cell_access();
		check_printing();
		check_random_traffic();

		wait_idle();
		// a final line advance may still be scrolling
		repeat (ROWS * COLS + 20) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

FILE: text_console_cursor_scroll.f
+incdir+src
src/tcon_pkg.sv
src/tcon_store.sv
src/text_console_cursor_scroll.sv
src/tcon_chk.sv
verif/tb_text_console_cursor_scroll.sv
